/* sv/rc4_pkg.sv */
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared codes and controller/datapath interface types for the RC4 generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rc4_pkg;

  // table geometry
  localparam int unsigned TableDepth = 256;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = AddrW + 1;

  // action codes
  localparam logic [1:0] ACT_RESTART = 2'd0;
  localparam logic [1:0] ACT_KEY     = 2'd1;
  localparam logic [1:0] ACT_GEN     = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_KEY_IGNORED = 2'd1;
  localparam logic [1:0] ST_NOT_KEYED   = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic       take;     // latch action and key of accepted transaction
    logic       restart;  // table to identity, clear indices and key count
    logic       rd_i;     // read S[i] (or S[i+1] when generating)
    logic       rd_j;     // read S[j'] and latch S[i]
    logic       wr_i;     // write S[i] <= S[j'], read S[sum]
    logic       wr_j;     // write S[j'] <= S[i], commit indices
    logic       load;     // load output register
    logic [1:0] status;   // status code for the output register
  } rc4_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic keyed;     // key schedule complete
    logic out_free;  // output register can take a result this cycle
  } rc4_sts_t;

endpackage

/* sv/rc4_ctrl.sv */
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for one transaction at a time: decodes the action, walks the
// read/swap steps of a key or generate transaction and hands off the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  rc4_pkg::rc4_sts_t sts,
  output rc4_pkg::rc4_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD_I = 3'd1;
  localparam logic [2:0] S_RD_J = 3'd2;
  localparam logic [2:0] S_WR_I = 3'd3;
  localparam logic [2:0] S_WR_J = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] st_code;
  logic [1:0] st_code_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  // next state and command decode
  always_comb begin
    state_next   = state;
    st_code_next = st_code;
    cmd          = '0;
    cmd.status   = rc4_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.take     = 1'b1;
          st_code_next = rc4_pkg::ST_OK;
          state_next   = S_FIN;
          unique case (action)
            rc4_pkg::ACT_RESTART: begin
              cmd.restart = 1'b1;
            end
            rc4_pkg::ACT_KEY: begin
              if (sts.keyed) begin
                st_code_next = rc4_pkg::ST_KEY_IGNORED;
              end else begin
                state_next = S_RD_I;
              end
            end
            rc4_pkg::ACT_GEN: begin
              if (sts.keyed) begin
                state_next = S_RD_I;
              end else begin
                st_code_next = rc4_pkg::ST_NOT_KEYED;
              end
            end
            default: begin
              st_code_next = rc4_pkg::ST_OK;
            end
          endcase
        end
      end
      S_RD_I: begin
        cmd.rd_i   = 1'b1;
        state_next = S_RD_J;
      end
      S_RD_J: begin
        cmd.rd_j   = 1'b1;
        state_next = S_WR_I;
      end
      S_WR_I: begin
        cmd.wr_i   = 1'b1;
        state_next = S_WR_J;
      end
      S_WR_J: begin
        // hold the final swap until the output register can take the result
        if (sts.out_free) begin
          cmd.wr_j   = 1'b1;
          cmd.load   = 1'b1;
          cmd.status = rc4_pkg::ST_OK;
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          cmd.status = st_code;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      st_code <= rc4_pkg::ST_OK;
    end else begin
      state   <= state_next;
      st_code <= st_code_next;
    end
  end

  // result is only loaded when the output side has room
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.out_free)
    else $error("output loaded while occupied");

  // the two swap writes always follow one another
  a_swap_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR_I) |=> (state == S_WR_J))
    else $error("swap write sequence broken");

  // early generate request is answered with an error and no table walk
  a_not_keyed: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == rc4_pkg::ACT_GEN) && !sts.keyed)
      |=> ((state == S_FIN) && (st_code == rc4_pkg::ST_NOT_KEYED)))
    else $error("unkeyed generate not rejected");

endmodule

/* sv/rc4_datapath.sv */
// ----------------------------------------------------------------------------
// rc4_datapath
// Permutation table memory with per-entry valid bits, index registers, key
// counter and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  rc4_pkg::rc4_cmd_t          cmd,
  output rc4_pkg::rc4_sts_t          sts,
  input  logic [1:0]                 action,
  input  logic [7:0]                 key_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [7:0]                 keystream_byte
);

  // permutation table; an entry not written since restart holds its address
  logic [7:0]                      mem [rc4_pkg::TableDepth];
  logic [rc4_pkg::TableDepth-1:0]  valid;

  logic [rc4_pkg::AddrW-1:0]  index_i;
  logic [rc4_pkg::AddrW-1:0]  index_j;
  logic [rc4_pkg::CountW-1:0] keys_loaded;
  logic [rc4_pkg::CountW-1:0] keys_loaded_next;

  logic [1:0] action_q;
  logic [7:0] key_q;
  logic       gen;

  logic [rc4_pkg::AddrW-1:0] raddr;
  logic [rc4_pkg::AddrW-1:0] raddr_q;
  logic                      rd_en;
  logic [7:0]                rdata_q;
  logic                      rvalid_q;
  logic [7:0]                rd_eff;

  logic [rc4_pkg::AddrW-1:0] waddr;
  logic [7:0]                wdata;
  logic                      we;

  logic [rc4_pkg::AddrW-1:0] ia;
  logic [rc4_pkg::AddrW-1:0] ia_calc;
  logic [rc4_pkg::AddrW-1:0] ja;
  logic [rc4_pkg::AddrW-1:0] ja_calc;
  logic [rc4_pkg::AddrW-1:0] sum;
  logic [rc4_pkg::AddrW-1:0] sum_calc;
  logic [7:0]                si;
  logic [7:0]                sj;
  logic [7:0]                ks;
  logic [7:0]                key_add;

  assign gen = (action_q == rc4_pkg::ACT_GEN);

  // table read: unwritten entries read as their own address
  assign rd_eff = rvalid_q ? rdata_q : raddr_q;

  // address arithmetic, all modulo table size
  assign key_add  = gen ? 8'd0 : key_q;
  assign ia_calc  = gen ? index_i + 8'd1 : index_i;
  assign ja_calc  = index_j + rd_eff + key_add;
  assign sum_calc = si + rd_eff;

  // single read port select
  always_comb begin
    rd_en = cmd.rd_i || cmd.rd_j || cmd.wr_i;
    raddr = ia_calc;
    if (cmd.rd_j) begin
      raddr = ja_calc;
    end else if (cmd.wr_i) begin
      raddr = sum_calc;
    end
  end

  // single write port select
  always_comb begin
    we    = cmd.wr_i || cmd.wr_j;
    waddr = cmd.wr_i ? ia : ja;
    wdata = cmd.wr_i ? rd_eff : si;
  end

  // output byte: forward the swapped entries, else the entry read at sum
  always_comb begin
    if (sum == ia) begin
      ks = sj;
    end else if (sum == ja) begin
      ks = si;
    end else begin
      ks = rd_eff;
    end
  end

  // key counter advance
  assign keys_loaded_next = keys_loaded + rc4_pkg::CountW'(1);

  // table memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
      raddr_q <= raddr;
    end
  end

  // valid bits and registered valid read
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      valid    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_q <= valid[raddr];
      end
    end
  end

  // transaction payload and step operands
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      action_q <= action;
      key_q    <= key_byte;
    end
    if (cmd.rd_i) begin
      ia <= ia_calc;
    end
    if (cmd.rd_j) begin
      si <= rd_eff;
      ja <= ja_calc;
    end
    if (cmd.wr_i) begin
      sj  <= rd_eff;
      sum <= sum_calc;
    end
  end

  // indices and key counter
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      index_i     <= '0;
      index_j     <= '0;
      keys_loaded <= '0;
    end else if (cmd.wr_j) begin
      if (gen) begin
        index_i <= ia;
        index_j <= ja;
      end else begin
        keys_loaded <= keys_loaded_next;
        if (keys_loaded_next[rc4_pkg::AddrW]) begin
          index_i <= '0;
          index_j <= '0;
        end else begin
          index_i <= ia + 8'd1;
          index_j <= ja;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status         <= cmd.status;
      keystream_byte <= (cmd.wr_j && gen) ? ks : 8'd0;
    end
  end

  assign sts.keyed    = keys_loaded[rc4_pkg::AddrW];
  assign sts.out_free = !out_valid || !out_stall;

  // key counter saturates at the table size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    !(keys_loaded[rc4_pkg::AddrW] && (|keys_loaded[rc4_pkg::AddrW-1:0])))
    else $error("key count beyond table size");

  // restart clears indices and counter
  a_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.restart |=> ((index_i == '0) && (index_j == '0) && (keys_loaded == '0)))
    else $error("restart did not clear state");

endmodule

/* sv/rc4_keystream_generator.sv */
// ----------------------------------------------------------------------------
// rc4_keystream_generator
// Key byte and generate transactions walk four dependent steps on the
// single-port table before their result is offered; restart, ignored key,
// early generate and unused actions go straight to the result hand-off. No
// new transaction is taken until the last result has been handed off.
// Reset puts the table to identity at once and clears indices and key count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_keystream_generator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] key_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [7:0] keystream_byte
);

  rc4_pkg::rc4_cmd_t cmd;
  rc4_pkg::rc4_sts_t sts;

  // sequencer
  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, indices and output register
  rc4_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .action         (action),
    .key_byte       (key_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .keystream_byte (keystream_byte)
  );

endmodule

/* verif/rc4_keystream_checker.sv */
// ----------------------------------------------------------------------------
// rc4_keystream_checker
// Watches both channels of the RC4 keystream generator. Keeps its own copy of
// the permutation table, indices and key count, predicts status and keystream
// byte for every accepted input transaction, and compares each accepted result
// with the oldest prediction. Reports the mismatch count and the number of
// predictions still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_keystream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  key_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [7:0]  keystream_byte,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] ks;
  } ks_result_t;

  // predicted table state
  logic [7:0]                 sbox [rc4_pkg::TableDepth];
  logic [7:0]                 idx_i;
  logic [7:0]                 idx_j;
  logic [rc4_pkg::CountW-1:0] keys_taken;

  ks_result_t  keystream_expected_q [$];
  int unsigned mismatches = 0;

  // identity table, indices and key count cleared
  function automatic void table_restart();
    for (int k = 0; k < int'(rc4_pkg::TableDepth); k++) sbox[k] = 8'(k);
    idx_i      = '0;
    idx_j      = '0;
    keys_taken = '0;
  endfunction

  function automatic void swap_entries(logic [7:0] a, logic [7:0] b);
    logic [7:0] t;
    t       = sbox[a];
    sbox[a] = sbox[b];
    sbox[b] = t;
  endfunction

  // append a prediction behind the ones still waiting
  function automatic void queue_expected(ks_result_t res);
    keystream_expected_q = {keystream_expected_q, res};
  endfunction

  // one transaction through the cipher state, returns the expected result
  function automatic ks_result_t predict_keystream(logic [1:0] act, logic [7:0] kb);
    ks_result_t res;
    logic [7:0] sum;
    res.status = rc4_pkg::ST_OK;
    res.ks     = '0;
    case (act)
      rc4_pkg::ACT_RESTART: begin
        table_restart();
      end
      rc4_pkg::ACT_KEY: begin
        if (keys_taken >= rc4_pkg::CountW'(rc4_pkg::TableDepth)) begin
          res.status = rc4_pkg::ST_KEY_IGNORED;
        end else begin
          idx_j = idx_j + sbox[idx_i] + kb;
          swap_entries(idx_i, idx_j);
          idx_i      = idx_i + 8'd1;
          keys_taken = keys_taken + rc4_pkg::CountW'(1);
          // schedule finished: both indices back to zero
          if (keys_taken >= rc4_pkg::CountW'(rc4_pkg::TableDepth)) begin
            idx_i = '0;
            idx_j = '0;
          end
        end
      end
      rc4_pkg::ACT_GEN: begin
        if (keys_taken < rc4_pkg::CountW'(rc4_pkg::TableDepth)) begin
          res.status = rc4_pkg::ST_NOT_KEYED;
        end else begin
          idx_i = idx_i + 8'd1;
          idx_j = idx_j + sbox[idx_i];
          swap_entries(idx_i, idx_j);
          sum    = sbox[idx_i] + sbox[idx_j];
          res.ks = sbox[sum];
        end
      end
      default: begin
        // unused action code leaves the state alone
      end
    endcase
    return res;
  endfunction

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin : watch
    ks_result_t want;
    if (rst) begin
      table_restart();
      keystream_expected_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        queue_expected(predict_keystream(action, key_byte));
      end
      if (out_valid && !out_stall) begin
        if (keystream_expected_q.size() == 0) begin
          $error("unexpected result: status %0d keystream_byte 0x%02h",
                 status, keystream_byte);
          mismatches++;
        end else begin
          want = keystream_expected_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
          end
          if (keystream_byte !== want.ks) begin
            $error("keystream_byte: expected 0x%02h, got 0x%02h",
                   want.ks, keystream_byte);
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= keystream_expected_q.size();
  end

endmodule

/* verif/tb_rc4_keystream_generator.sv */
// ----------------------------------------------------------------------------
// tb_rc4_keystream_generator
// Drives the RC4 keystream generator with a short directed run of early
// generates, unused actions, key extremes and restarts, then random keying
// sessions (full and cut-short schedules) followed by keystream generation
// with ignored keys and unused actions mixed in. Both channels idle at random;
// one long result hold-off fills the block. Checking is done beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rc4_keystream_generator;

  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam int unsigned ITEM_TARGET = 1650;
  localparam int unsigned HOLD_CYCLES = 300;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [1:0] action    = rc4_pkg::ACT_RESTART;
  logic [7:0] key_byte  = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] status;
  logic [7:0] keystream_byte;

  int unsigned fail_count;
  int unsigned pending;

  // every input transaction taken by the block
  int unsigned items_sent = 0;

  // shared between sender and receiver processes
  bit idle_mode     = 1'b0;
  bit hold_results  = 1'b0;

  always #5 clk = ~clk;

  rc4_keystream_generator dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .key_byte       (key_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .keystream_byte (keystream_byte)
  );

  rc4_keystream_checker u_keystream_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .key_byte       (key_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .keystream_byte (keystream_byte),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // half the time no gap, often a short one, now and then a long one
  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one transaction and wait until it is taken
  task automatic send_item(input logic [1:0] act, input logic [7:0] kb);
    int unsigned gap;
    gap = idle_mode ? 0 : random_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    key_byte <= kb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // stop offering until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // result side: random stalls, or one long hold-off on request
  initial begin : result_sink
    int unsigned stall_len;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        hold_results = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        stall_len = idle_mode ? 0 : random_gap();
        if (stall_len != 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int unsigned session;
    int unsigned nkeys;
    int unsigned ngen;
    int unsigned r;
    session    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: early generates, unused action, key extremes, restarts
    send_item(rc4_pkg::ACT_GEN, 8'h00);
    send_item(ACT_UNUSED, 8'hFF);
    send_item(rc4_pkg::ACT_KEY, 8'h00);
    send_item(rc4_pkg::ACT_KEY, 8'hFF);
    send_item(rc4_pkg::ACT_GEN, 8'hFF);
    send_item(ACT_UNUSED, 8'h00);
    send_item(rc4_pkg::ACT_RESTART, 8'hA5);
    send_item(rc4_pkg::ACT_KEY, 8'hFF);
    send_item(rc4_pkg::ACT_KEY, 8'h00);
    send_item(rc4_pkg::ACT_RESTART, 8'hFF);
    send_item(rc4_pkg::ACT_GEN, 8'h5A);
    send_item(rc4_pkg::ACT_KEY, 8'h80);
    send_item(rc4_pkg::ACT_RESTART, 8'h00);
    wait_drained();

    // random keying sessions followed by keystream generation
    while (items_sent < ITEM_TARGET) begin
      idle_mode = ($urandom_range(0, 5) == 0);
      send_item(rc4_pkg::ACT_RESTART, 8'($urandom_range(0, 255)));

      // first session always completes its schedule; later ones sometimes cut short
      if (session != 0 && $urandom_range(0, 4) == 0) nkeys = $urandom_range(0, 255);
      else nkeys = rc4_pkg::TableDepth;

      for (int k = 0; k < nkeys; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) send_item(rc4_pkg::ACT_GEN, 8'($urandom_range(0, 255)));
        else if (r < 4) send_item(ACT_UNUSED, 8'($urandom_range(0, 255)));
        send_item(rc4_pkg::ACT_KEY, 8'($urandom_range(0, 255)));
      end

      // long result hold-off while generates keep coming
      if (session == 1) begin
        idle_mode    = 1'b1;
        hold_results = 1'b1;
      end

      ngen = $urandom_range(10, 120);
      for (int g = 0; g < ngen; g++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_item(rc4_pkg::ACT_KEY, 8'($urandom_range(0, 255)));
        end else if (r < 7) begin
          send_item(ACT_UNUSED, 8'($urandom_range(0, 255)));
        end else begin
          send_item(rc4_pkg::ACT_GEN, 8'($urandom_range(0, 255)));
        end
      end

      if (session % 2 == 0) wait_drained();
      session++;
    end

    idle_mode = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
